@@ rtl/tmc_pkg.sv @@
// Shared constants, types and register codes for the texture matrix composer.
package tmc_pkg;

  localparam int FracBits  = 16;
  localparam int AngleBits = 16;
  localparam int RemBits   = AngleBits - 2;
  localparam int CordicIters = 30;

  localparam int DataW = 32;
  localparam int WideW = 66;

  // Register indexes
  localparam logic [2:0] REG_TU = 3'd0;
  localparam logic [2:0] REG_TV = 3'd1;
  localparam logic [2:0] REG_SU = 3'd2;
  localparam logic [2:0] REG_SV = 3'd3;
  localparam logic [2:0] REG_RT = 3'd4;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
  localparam logic signed [WideW-1:0] OneW = WideW'(1) <<< FracBits;

  typedef logic signed [WideW-1:0] wide_t;
  typedef logic [4:0] enables_t;

  // Arctangent of 2^-i in Q30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] a;
    unique case (i)
      5'd0: a = 34'sd843314857;
      5'd1: a = 34'sd497837829;
      5'd2: a = 34'sd263043837;
      5'd3: a = 34'sd133525159;
      5'd4: a = 34'sd67021687;
      5'd5: a = 34'sd33543516;
      5'd6: a = 34'sd16775851;
      5'd7: a = 34'sd8388437;
      5'd8: a = 34'sd4194283;
      5'd9: a = 34'sd2097149;
      default: a = 34'sd1 <<< (5'd30 - i);
    endcase
    return a;
  endfunction

  // Saturate to 32 bits signed
  function automatic logic [31:0] sat32(input wide_t x);
    if (x > wide_t'(64'sd2147483647)) return 32'h7FFF_FFFF;
    if (x < -wide_t'(64'sd2147483648)) return 32'h8000_0000;
    return x[31:0];
  endfunction

endpackage

@@ rtl/texture_matrix_composer_top.sv @@
// Texture matrix composer: settings capture, serial divide, CORDIC and matrix assembly.
// One value in produces one 2x3 matrix out. Work per item is sequential: two
// 33-step restoring divides (one quotient bit per cycle), 30 CORDIC steps, a
// register load of sine and cosine, then a six-entry rotation pass (one entry per
// cycle) or a direct copy of the entries when the rotation is zero, and a load of
// the result register. The next value is taken once the result register is free.
// Enable registers sit on the APB port at 4*index; they may be written only
// while the block is idle.
module texture_matrix_composer_top
  import tmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid,
  output logic        stall,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] m00,
  output logic signed [31:0] m01,
  output logic signed [31:0] m02,
  output logic signed [31:0] m10,
  output logic signed [31:0] m11,
  output logic signed [31:0] m12,
  output logic signed [31:0] readback
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVU = 3'd1;
  localparam logic [2:0] S_DIVV = 3'd2;
  localparam logic [2:0] S_CORD = 3'd3;
  localparam logic [2:0] S_ROT  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]  state;
  enables_t    en;
  logic [31:0] u_offset, v_offset, u_scale, v_scale;
  logic [AngleBits-1:0] rotation_turns;
  logic [5:0]  cnt;

  // Divider: restoring, magnitudes, one bit per cycle
  logic [32:0] dvd;      // dividend shift register (2^32 fits in 33 bits)
  logic [32:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic        qneg;
  wide_t       r00, r11;

  // CORDIC
  logic signed [33:0] cx, cy, cz;
  logic [1:0]  quad;
  logic signed [17:0] cc, ss;

  // Matrix working registers
  wide_t       w00, w02, w11, w12;
  logic [31:0] o00, o01, o02, o10, o11, o12;

  assign pready = 1'b1;

  // Read back the enable selected by the address
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_TU: prdata[0] = en[0];
      REG_TV: prdata[0] = en[1];
      REG_SU: prdata[0] = en[2];
      REG_SV: prdata[0] = en[3];
      REG_RT: prdata[0] = en[4];
      default: ;
    endcase
  end

  assign stall  = (state != S_IDLE) || out_valid;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      en <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_TU: en[0] <= pwdata[0];
        REG_TV: en[1] <= pwdata[1 - 1];
        REG_SU: en[2] <= pwdata[0];
        REG_SV: en[3] <= pwdata[0];
        REG_RT: en[4] <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Divider step helpers
  logic [33:0] rem_sh;
  logic [33:0] rem_sub;
  always_comb begin
    rem_sh  = {rem, dvd[32]};
    rem_sub = rem_sh - {2'b0, dvs};
  end

  function automatic wide_t div_result(input logic [32:0] q, input logic neg);
    wide_t v;
    v = neg ? -$signed({33'd0, q}) : $signed({33'd0, q});
    return wide_t'($signed(sat32(v)));
  endfunction

  // Magnitude of a signed scale, the divisor of 2^(2*FracBits)
  function automatic logic [31:0] mag(input logic [31:0] s);
    return s[31] ? (~s + 32'd1) : s;
  endfunction

  // CORDIC step
  logic signed [33:0] dx, dy, at;
  always_comb begin
    dx = cy >>> cnt[4:0];
    dy = cx >>> cnt[4:0];
    at = atan_q30(cnt[4:0]);
  end

  // Rotation pass: one product pair per cycle
  logic signed [33:0] pa, pb;
  logic signed [17:0] ma, mb;
  logic signed [51:0] prod_a, prod_b;
  wide_t pd, acc;
  logic [2:0] ridx;
  always_comb begin
    pa = '0; pb = '0;
    ridx = cnt[2:0];
    unique case (ridx)
      3'd0: begin pa = 34'(w00); pb = '0; end
      3'd1: begin pa = '0;       pb = 34'(w11); end
      3'd2: begin pa = 34'(w02); pb = 34'(w12); end
      3'd3: begin pa = 34'(w00); pb = '0; end
      3'd4: begin pa = '0;       pb = 34'(w11); end
      default: begin pa = 34'(w02); pb = 34'(w12); end
    endcase
    ma = (ridx < 3'd3) ? cc : ss;
    mb = (ridx < 3'd3) ? ss : cc;
    prod_a = ma * pa;
    prod_b = mb * pb;
    if (ridx < 3'd3) begin
      // c*a - s*b + (1 - c + s)*h
      pd  = (ridx == 3'd2) ?
            (OneW - wide_t'(cc) + wide_t'(ss)) <<< (FracBits - 1) : '0;
      acc = wide_t'(prod_a) - wide_t'(prod_b) + pd;
    end else begin
      pd  = (ridx == 3'd5) ?
            (OneW - wide_t'(ss) - wide_t'(cc)) <<< (FracBits - 1) : '0;
      acc = wide_t'(prod_a) + wide_t'(prod_b) + pd;
    end
  end
  wide_t rnd;
  assign rnd = (acc + (wide_t'(1) <<< (FracBits - 1))) >>> FracBits;

  logic [AngleBits-1:0] rot_cap;
  assign rot_cap = value[FracBits-1 -: AngleBits];

  logic [31:0] new_su, new_sv, new_uo, new_vo;
  logic [AngleBits-1:0] new_rt;
  always_comb begin
    new_uo = en[0] ? value : u_offset;
    new_vo = en[1] ? value : v_offset;
    new_su = en[2] ? value : u_scale;
    new_sv = en[3] ? value : v_scale;
    new_rt = en[4] ? rot_cap : rotation_turns;
  end

  logic scale_on, off_on;
  assign scale_on = (u_scale != 32'h0001_0000) || (v_scale != 32'h0001_0000);
  assign off_on   = (u_offset != '0) || (v_offset != '0);

  wide_t cc_r, ss_r;
  always_comb begin
    unique case (quad)
      2'd0: begin cc_r = wide_t'(cx);  ss_r = wide_t'(cy);  end
      2'd1: begin cc_r = -wide_t'(cy); ss_r = wide_t'(cx);  end
      2'd2: begin cc_r = -wide_t'(cx); ss_r = -wide_t'(cy); end
      default: begin cc_r = wide_t'(cy); ss_r = -wide_t'(cx); end
    endcase
    cc_r = (cc_r + (wide_t'(1) <<< (29 - FracBits))) >>> (30 - FracBits);
    ss_r = (ss_r + (wide_t'(1) <<< (29 - FracBits))) >>> (30 - FracBits);
    if (cc_r > OneW) cc_r = OneW;
    if (cc_r < -OneW) cc_r = -OneW;
    if (ss_r > OneW) ss_r = OneW;
    if (ss_r < -OneW) ss_r = -OneW;
  end

  logic [63:0] zmul;
  assign zmul = 64'(rotation_turns[RemBits-1:0]) * 64'(HalfPiQ30);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      u_offset <= '0; v_offset <= '0;
      u_scale <= 32'h0001_0000; v_scale <= 32'h0001_0000;
      rotation_turns <= '0;
      cnt <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (valid && !stall) begin
            u_offset <= new_uo; v_offset <= new_vo;
            u_scale <= new_su;  v_scale <= new_sv;
            rotation_turns <= new_rt;
            dvs  <= mag(new_su);
            qneg <= new_su[31];
            dvd  <= 33'h1_0000_0000;
            rem  <= '0; quo <= '0;
            cnt  <= '0;
            state <= S_DIVU;
          end
        end
        S_DIVU, S_DIVV: begin
          if (cnt == 6'd32) begin
            cnt <= '0;
            if (state == S_DIVU) begin
              r00 <= (dvs == '0) ? wide_t'(32'sh7FFF_FFFF)
                     : div_result({quo[31:0], !rem_sub[33]}, qneg);
              dvs  <= mag(v_scale);
              qneg <= v_scale[31];
              dvd  <= 33'h1_0000_0000;
              rem  <= '0; quo <= '0;
              state <= S_DIVV;
            end else begin
              r11 <= (dvs == '0) ? wide_t'(32'sh7FFF_FFFF)
                     : div_result({quo[31:0], !rem_sub[33]}, qneg);
              cx <= CordicGain; cy <= '0;
              cz <= 34'(zmul >> RemBits);
              quad <= rotation_turns[AngleBits-1 -: 2];
              state <= S_CORD;
            end
          end else begin
            dvd <= dvd << 1;
            if (!rem_sub[33]) begin
              rem <= rem_sub[32:0];
              quo <= {quo[31:0], 1'b1};
            end else begin
              rem <= rem_sh[32:0];
              quo <= {quo[31:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
          end
        end
        S_CORD: begin
          if (cnt == 6'd0) begin
            if (scale_on) begin
              w00 <= r00; w11 <= r11;
              w02 <= (OneW - r00) >>> 1;
              w12 <= (OneW - r11) >>> 1;
            end else begin
              w00 <= OneW; w11 <= OneW; w02 <= '0; w12 <= '0;
            end
          end else if (cnt == 6'd1 && off_on) begin
            w02 <= w02 + wide_t'($signed(u_offset));
            w12 <= w12 + wide_t'($signed(v_offset));
          end
          if (!cz[33]) begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - at;
          end else begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + at;
          end
          if (cnt == 6'(CordicIters - 1)) begin
            cnt <= '0;
            state <= S_ROT;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_ROT: begin
          if (cnt == 6'd0) begin
            cc <= 18'(cc_r); ss <= 18'(ss_r);
            cnt <= 6'd8;
          end else if (rotation_turns == '0) begin
            o00 <= sat32(w00); o01 <= '0; o02 <= sat32(w02);
            o10 <= '0; o11 <= sat32(w11); o12 <= sat32(w12);
            state <= S_DONE;
          end else begin
            // cnt 8..13 stand for entries 0..5
            cnt <= cnt + 6'd1;
            unique case (cnt[2:0])
              3'd0: o00 <= sat32(rnd);
              3'd1: o01 <= sat32(rnd);
              3'd2: o02 <= sat32(rnd);
              3'd3: o10 <= sat32(rnd);
              3'd4: o11 <= sat32(rnd);
              default: o12 <= sat32(rnd);
            endcase
            if (cnt == 6'd13) state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            m00 <= o00; m01 <= o01; m02 <= o02;
            m10 <= o10; m11 <= o11; m12 <= o12;
            readback <= en[0] ? o02 : en[1] ? o12 : en[2] ? o00 : en[3] ? o11 : '0;
            out_valid <= 1'b1;
            cnt <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/tmc_checker.sv @@
// Port-level checks for the texture matrix composer, bound to the top level.
module tmc_checker (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic stall,
  input logic out_valid,
  input logic out_stall,
  input logic [31:0] m00,
  input logic [31:0] m11
);

  // Result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(m00) && $stable(m11))
    else $error("result changed under stall");

  // No acceptance while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stall)
    else $error("input taken while result pending");

  // An accepted item is not answered in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    valid && !stall |=> !out_valid)
    else $error("result too early");

endmodule

bind texture_matrix_composer_top tmc_checker u_tmc_checker (
  .clk(clk), .rst(rst), .valid(valid), .stall(stall),
  .out_valid(out_valid), .out_stall(out_stall), .m00(m00), .m11(m11)
);
